// File: src/uls_pkg.sv
`default_nettype none
package uls_pkg;

  localparam int OFFSET_BITS = 31;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [OFFSET_BITS-1:0] off_t;

  localparam off_t OFF_MAX = '1;

  // partial multi-byte line end: C2 seen, E2 seen, E2 80 seen
  typedef enum logic [1:0] {
    PM_IDLE,
    PM_C2,
    PM_E2,
    PM_E280
  } pm_t;

  typedef struct packed {
    off_t start;
    off_t stop;
    logic fin;
  } line_t;

  // one request's worth of results: one or two lines
  typedef struct packed {
    line_t line0;
    line_t line1;
    logic  two;
    logic  ovf;
  } entry_t;

endpackage
`default_nettype wire

// File: src/uls_front.sv
`default_nettype none
module uls_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      data_byte,
  input  wire logic            byte_present,
  input  wire logic            end_of_string,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic            cfg_data,
  input  wire logic            q_full,
  output logic                 push,
  output uls_pkg::entry_t      entry
);
  import uls_pkg::*;

  localparam logic [1:0] CFG_DROP_EMPTY = 2'd0;
  localparam logic [1:0] CFG_NO_TAIL    = 2'd1;

  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_VT   = 8'h0B;
  localparam logic [7:0] BYTE_FF   = 8'h0C;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_C2   = 8'hC2;
  localparam logic [7:0] BYTE_E2   = 8'hE2;
  localparam logic [7:0] BYTE_80   = 8'h80;
  localparam logic [7:0] BYTE_NEL2 = 8'h85;
  localparam logic [7:0] BYTE_LS3  = 8'hA8;
  localparam logic [7:0] BYTE_PS3  = 8'hA9;

  typedef struct packed {
    line_t      line0;
    line_t      line1;
    logic [1:0] n;
  } acc_t;

  function automatic acc_t acc_push(acc_t a, off_t s, off_t e, logic f);
    acc_t r;
    r = a;
    if (a.n == 2'd0) begin
      r.line0 = '{start: s, stop: e, fin: f};
      r.n     = 2'd1;
    end else if (a.n == 2'd1) begin
      r.line1 = '{start: s, stop: e, fin: f};
      r.n     = 2'd2;
    end
    return r;
  endfunction

  // open line is sure to be reported later
  function automatic logic tail_certain(logic lo, logic lnt, off_t cs, off_t ce, logic eon);
    if (lo) return ce != cs;
    if (lnt) return !eon;
    return 1'b1;
  endfunction

  logic cfg_omit, cfg_no_tail;
  off_t byte_offset, current_start, current_end, partial_offset, held_start, held_end;
  pm_t  partial_match;
  logic cr_pending, ended_on_newline, overflow_seen, held_valid, in_string;
  logic lat_omit, lat_no_tail;

  off_t byte_offset_next, current_start_next, current_end_next, partial_offset_next;
  off_t held_start_next, held_end_next;
  pm_t  partial_match_next;
  logic cr_pending_next, ended_on_newline_next, overflow_seen_next, held_valid_next;
  logic in_string_next, lat_omit_next, lat_no_tail_next;

  logic accept;
  acc_t acc;
  off_t pos, nxt, nl_start;
  logic do_nl, ovf_out;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall && (byte_present || end_of_string);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_omit    <= 1'b0;
      cfg_no_tail <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DROP_EMPTY: cfg_omit    <= cfg_data;
        CFG_NO_TAIL:    cfg_no_tail <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    byte_offset_next      = byte_offset;
    current_start_next    = current_start;
    current_end_next      = current_end;
    partial_offset_next   = partial_offset;
    partial_match_next    = partial_match;
    cr_pending_next       = cr_pending;
    ended_on_newline_next = ended_on_newline;
    overflow_seen_next    = overflow_seen;
    held_valid_next       = held_valid;
    held_start_next       = held_start;
    held_end_next         = held_end;
    in_string_next        = in_string;
    lat_omit_next         = lat_omit;
    lat_no_tail_next      = lat_no_tail;
    acc                   = '0;
    pos                   = byte_offset;
    nxt                   = byte_offset;
    nl_start              = byte_offset;
    do_nl                 = 1'b0;
    ovf_out               = overflow_seen;

    if (accept) begin
      if (!in_string) begin
        in_string_next   = 1'b1;
        lat_omit_next    = cfg_omit;
        lat_no_tail_next = cfg_no_tail;
      end
      if (byte_present) begin
        if (pos == OFF_MAX) begin
          nxt                = OFF_MAX;
          overflow_seen_next = 1'b1;
        end else begin
          nxt = pos + off_t'(1);
        end
        if (cr_pending && data_byte == BYTE_LF) begin
          // LF completing CRLF
          cr_pending_next    = 1'b0;
          current_start_next = nxt;
          current_end_next   = nxt;
        end else begin
          cr_pending_next = 1'b0;
          if (ended_on_newline_next) begin
            ended_on_newline_next = 1'b0;
            if (held_valid_next && tail_certain(lat_omit_next, lat_no_tail_next,
                current_start_next, current_end_next, ended_on_newline_next)) begin
              acc = acc_push(acc, held_start_next, held_end_next, 1'b0);
              held_valid_next = 1'b0;
            end
          end
          if ((partial_match_next == PM_C2 && data_byte == BYTE_NEL2) ||
              (partial_match_next == PM_E280 &&
               (data_byte == BYTE_LS3 || data_byte == BYTE_PS3))) begin
            partial_match_next = PM_IDLE;
            do_nl              = 1'b1;
            nl_start           = partial_offset_next;
          end else if (partial_match_next == PM_E2 && data_byte == BYTE_80) begin
            partial_match_next = PM_E280;
          end else begin
            if (partial_match_next != PM_IDLE) begin
              // broken sequence: its bytes are text
              current_end_next   = pos;
              partial_match_next = PM_IDLE;
              if (held_valid_next && tail_certain(lat_omit_next, lat_no_tail_next,
                  current_start_next, current_end_next, ended_on_newline_next)) begin
                acc = acc_push(acc, held_start_next, held_end_next, 1'b0);
                held_valid_next = 1'b0;
              end
            end
            case (data_byte)
              BYTE_LF, BYTE_VT, BYTE_FF: begin
                do_nl    = 1'b1;
                nl_start = pos;
              end
              BYTE_CR: begin
                do_nl           = 1'b1;
                nl_start        = pos;
                cr_pending_next = 1'b1;
              end
              BYTE_C2: begin
                partial_match_next  = PM_C2;
                partial_offset_next = pos;
              end
              BYTE_E2: begin
                partial_match_next  = PM_E2;
                partial_offset_next = pos;
              end
              default: begin
                current_end_next = nxt;
                if (held_valid_next && tail_certain(lat_omit_next, lat_no_tail_next,
                    current_start_next, current_end_next, ended_on_newline_next)) begin
                  acc = acc_push(acc, held_start_next, held_end_next, 1'b0);
                  held_valid_next = 1'b0;
                end
              end
            endcase
          end
          if (do_nl) begin
            if (!(lat_omit_next && current_end_next == current_start_next)) begin
              if (held_valid_next) acc = acc_push(acc, held_start_next, held_end_next, 1'b0);
              held_start_next = current_start_next;
              held_end_next   = nl_start;
              held_valid_next = 1'b1;
            end
            current_start_next    = nxt;
            current_end_next      = nxt;
            ended_on_newline_next = 1'b1;
            if (held_valid_next && tail_certain(lat_omit_next, lat_no_tail_next,
                current_start_next, current_end_next, ended_on_newline_next)) begin
              acc = acc_push(acc, held_start_next, held_end_next, 1'b0);
              held_valid_next = 1'b0;
            end
          end
        end
        byte_offset_next = nxt;
      end
      ovf_out = overflow_seen_next;

      if (end_of_string) begin
        if (partial_match_next != PM_IDLE) begin
          current_end_next   = byte_offset_next;
          partial_match_next = PM_IDLE;
          if (held_valid_next && tail_certain(lat_omit_next, lat_no_tail_next,
              current_start_next, current_end_next, ended_on_newline_next)) begin
            acc = acc_push(acc, held_start_next, held_end_next, 1'b0);
            held_valid_next = 1'b0;
          end
        end
        if (tail_certain(lat_omit_next, lat_no_tail_next, current_start_next,
            current_end_next, ended_on_newline_next)) begin
          if (held_valid_next) acc = acc_push(acc, held_start_next, held_end_next, 1'b0);
          acc = acc_push(acc, current_start_next, current_end_next, 1'b1);
        end else if (held_valid_next) begin
          acc = acc_push(acc, held_start_next, held_end_next, 1'b1);
        end
        // back to the state of a fresh string
        byte_offset_next      = '0;
        current_start_next    = '0;
        current_end_next      = '0;
        partial_match_next    = PM_IDLE;
        partial_offset_next   = '0;
        cr_pending_next       = 1'b0;
        ended_on_newline_next = 1'b0;
        overflow_seen_next    = 1'b0;
        held_valid_next       = 1'b0;
        in_string_next        = 1'b0;
      end
    end
  end

  assign push        = accept && (acc.n != 2'd0);
  assign entry.line0 = acc.line0;
  assign entry.line1 = acc.line1;
  assign entry.two   = (acc.n == 2'd2);
  assign entry.ovf   = ovf_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      current_start    <= '0;
      current_end      <= '0;
      partial_match    <= PM_IDLE;
      cr_pending       <= 1'b0;
      ended_on_newline <= 1'b0;
      overflow_seen    <= 1'b0;
      held_valid       <= 1'b0;
      in_string        <= 1'b0;
      lat_omit         <= 1'b0;
      lat_no_tail      <= 1'b0;
    end else begin
      byte_offset      <= byte_offset_next;
      current_start    <= current_start_next;
      current_end      <= current_end_next;
      partial_match    <= partial_match_next;
      cr_pending       <= cr_pending_next;
      ended_on_newline <= ended_on_newline_next;
      overflow_seen    <= overflow_seen_next;
      held_valid       <= held_valid_next;
      in_string        <= in_string_next;
      lat_omit         <= lat_omit_next;
      lat_no_tail      <= lat_no_tail_next;
    end
  end

  always_ff @(posedge clk) begin
    partial_offset <= partial_offset_next;
    held_start     <= held_start_next;
    held_end       <= held_end_next;
  end

endmodule
`default_nettype wire

// File: src/uls_queue.sv
`default_nettype none
module uls_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  uls_pkg::entry_t      wdata,
  output logic                 full,
  input  wire logic            pop,
  output logic                 rvalid,
  output uls_pkg::entry_t      rdata
);
  import uls_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  logic do_push, do_pop;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rvalid  = (count != '0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/uls_back.sv
`default_nettype none
module uls_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  uls_pkg::entry_t      q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [30:0]          line_start,
  output logic [30:0]          line_end,
  output logic                 final_line,
  output logic                 last_in_run,
  output logic                 offset_overflow
);
  import uls_pkg::*;

  logic  sel;   // next line of the head entry to send
  logic  load;
  line_t pick;
  logic  pick_last;

  assign load      = q_valid && (!out_valid || !out_stall);
  assign pick      = sel ? q_data.line1 : q_data.line0;
  assign pick_last = sel || !q_data.two;
  assign pop       = load && pick_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= !pick_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_start      <= 31'(pick.start);
      line_end        <= 31'(pick.stop);
      final_line      <= pick.fin;
      last_in_run     <= pick_last;
      offset_overflow <= q_data.ovf;
    end
  end

endmodule
`default_nettype wire

// File: src/utf8_line_splitter.sv
// UTF-8 line splitter.
// Input channel (in_valid / in_stall): one request per byte of a string, with
// byte_present low for an end-only request and end_of_string marking the last.
// Output channel (out_valid / out_stall): one request per line, giving the
// byte span [line_start, line_end), final_line, last_in_run and
// offset_overflow. A byte causes zero, one or two lines.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 drops empty
// lines, index 1 opens no tail after a closing newline; sampled by the first
// request of a string.
// Path: with the queue empty and the output free, a line is written into the
// queue when the byte that completes it is accepted, then loaded into the output register.
// Throughput: one byte per cycle while in_stall is low; the output register sends
// one line per cycle while out_stall is low, so the two lines of a byte go out
// one after the other, absorbed by the four-entry queue between front and back.
// Receiver stall: the output holds, the queue fills, and in_stall rises when
// the queue is full.
// Reset: sync, active high; clears string state, queue and config (both 0).
`default_nettype none
module utf8_line_splitter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_string,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      line_start,
  output logic [30:0]      line_end,
  output logic             final_line,
  output logic             last_in_run,
  output logic             offset_overflow
);
  import uls_pkg::*;

  logic   push, q_full, q_valid, pop;
  entry_t push_data, q_data;

  uls_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .end_of_string (end_of_string),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .push          (push),
    .entry         (push_data)
  );

  uls_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_data),
    .full   (q_full),
    .pop    (pop),
    .rvalid (q_valid),
    .rdata  (q_data)
  );

  uls_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .line_start      (line_start),
    .line_end        (line_end),
    .final_line      (final_line),
    .last_in_run     (last_in_run),
    .offset_overflow (offset_overflow)
  );

  // a byte that produced lines leaves the queue non-empty
  assert property (@(posedge clk) disable iff (rst) push |=> q_valid)
    else $error("queue empty after push");

  // the second line of a pair follows straight after the first
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_in_run |=> out_valid)
    else $error("second line of a pair missing");

  // the front never offers lines while the queue is full
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("push into full queue");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
